FILE: design/mcsg_pkg.sv
`timescale 1ns / 1ps

package mcsg_pkg;

    localparam int CENTRE_BITS = 10;
    localparam int RADIUS_BITS = 4;
    localparam int COORD_W     = 12;
    localparam int DISC_W      = 7;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 40;

    // which of the seven pair shapes the output register takes
    typedef enum logic [2:0] {
        SEL_AXIS_HI,
        SEL_AXIS_LO,
        SEL_CENTRE,
        SEL_Q0,
        SEL_Q1,
        SEL_Q2,
        SEL_Q3
    } pair_sel_t;

    typedef struct packed {
        logic      load;
        logic      step;
        logic      emit;
        logic      last;
        pair_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic walk_more;
    } dp_status_t;

endpackage

FILE: design/mcsg_datapath.sv
`timescale 1ns / 1ps

module mcsg_datapath #(
    parameter int MAX_RADIUS = 15,
    parameter int COORD_BITS = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [mcsg_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tuser,
    input  mcsg_pkg::dp_cmd_t                cmd,
    output mcsg_pkg::dp_status_t             status,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mcsg_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tuser,
    output logic                             m_tlast
);

    localparam int CBW = mcsg_pkg::CENTRE_BITS;
    localparam int RW  = mcsg_pkg::RADIUS_BITS;
    localparam int CW  = mcsg_pkg::COORD_W;
    localparam int DW  = mcsg_pkg::DISC_W;
    localparam int CB  = (COORD_BITS < CBW) ? COORD_BITS : CBW;
    localparam logic [CBW-1:0] CMASK = CBW'((1 << CB) - 1);

    logic [CBW-1:0]       cx_reg, cy_reg;
    logic [RW-1:0]        r_reg;
    logic                 fill_reg;
    logic [RW-1:0]        x_reg, x_next;
    logic [RW-1:0]        y_reg, y_next;
    logic signed [DW-1:0] d_reg, d_next;

    logic [CW-1:0]        xl_reg, xr_reg, row_reg;
    logic                 mfill_reg, mlast_reg, mvalid_reg;

    logic [RW-1:0]        r_in, r_clamp;
    logic [RW-1:0]        x_inc, y_dec;
    logic signed [DW-1:0] diff;
    logic [RW-1:0]        h_off, v_off;
    logic                 v_neg;
    logic [CW-1:0]        cx12, cy12, h12, v12;

    assign r_in    = s_tdata[2*CBW +: RW];
    assign r_clamp = (int'(r_in) > MAX_RADIUS) ? RW'(MAX_RADIUS) : r_in;

    // one midpoint step
    assign x_inc = x_reg + RW'(1);
    assign y_dec = y_reg - RW'(1);
    assign diff  = $signed(DW'(x_inc)) - $signed(DW'(y_dec));

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        d_next = d_reg;
        if (cmd.load)
        begin
            x_next = '0;
            y_next = r_clamp;
            d_next = $signed(DW'(1)) - $signed(DW'(r_clamp));
        end
        else if (cmd.step)
        begin
            x_next = x_inc;
            if (d_reg <= 0)
            begin
                d_next = d_reg + $signed({{(DW-RW-1){1'b0}}, x_inc, 1'b1});
            end
            else
            begin
                y_next = y_dec;
                d_next = d_reg + $signed({diff[DW-2:0], 1'b1});
            end
        end
    end

    always_comb
    begin
        h_off = '0;
        v_off = '0;
        v_neg = 1'b0;
        unique case (cmd.sel)
            mcsg_pkg::SEL_AXIS_HI: v_off = r_reg;
            mcsg_pkg::SEL_AXIS_LO:
            begin
                v_off = r_reg;
                v_neg = 1'b1;
            end
            mcsg_pkg::SEL_CENTRE:  h_off = r_reg;
            mcsg_pkg::SEL_Q0:
            begin
                h_off = y_reg;
                v_off = x_reg;
            end
            mcsg_pkg::SEL_Q1:
            begin
                h_off = y_reg;
                v_off = x_reg;
                v_neg = 1'b1;
            end
            mcsg_pkg::SEL_Q2:
            begin
                h_off = x_reg;
                v_off = y_reg;
            end
            mcsg_pkg::SEL_Q3:
            begin
                h_off = x_reg;
                v_off = y_reg;
                v_neg = 1'b1;
            end
            default:
            begin
                h_off = '0;
                v_off = '0;
            end
        endcase
    end

    assign cx12 = CW'(cx_reg);
    assign cy12 = CW'(cy_reg);
    assign h12  = CW'(h_off);
    assign v12  = CW'(v_off);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg      <= '0;
            y_reg      <= '0;
            d_reg      <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            d_reg <= d_next;
            if (cmd.emit)
            begin
                mvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg   <= s_tdata[0 +: CBW] & CMASK;
            cy_reg   <= s_tdata[CBW +: CBW] & CMASK;
            r_reg    <= r_clamp;
            fill_reg <= s_tuser;
        end
        if (cmd.emit)
        begin
            xl_reg    <= cx12 - h12;
            xr_reg    <= cx12 + h12;
            row_reg   <= v_neg ? (cy12 - v12) : (cy12 + v12);
            mfill_reg <= fill_reg;
            mlast_reg <= cmd.last;
        end
    end

    assign status.out_free  = !mvalid_reg || m_tready;
    assign status.walk_more = x_reg < y_reg;

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {{(mcsg_pkg::M_TDATA_W - 3*CW){1'b0}}, row_reg, xr_reg, xl_reg};
    assign m_tuser  = mfill_reg;
    assign m_tlast  = mlast_reg;

endmodule

FILE: design/mcsg_ctrl.sv
`timescale 1ns / 1ps

module mcsg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  mcsg_pkg::dp_status_t status,
    output mcsg_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AXIS_HI,
        ST_AXIS_LO,
        ST_CENTRE,
        ST_QUAD
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] quad_reg, quad_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        quad_next  = quad_reg;
        cmd        = '0;
        cmd.sel    = mcsg_pkg::SEL_AXIS_HI;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_AXIS_HI;
                end
            end
            ST_AXIS_HI:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = mcsg_pkg::SEL_AXIS_HI;
                    state_next = ST_AXIS_LO;
                end
            end
            ST_AXIS_LO:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = mcsg_pkg::SEL_AXIS_LO;
                    state_next = ST_CENTRE;
                end
            end
            ST_CENTRE:
            begin
                // centre row does not use x/y, so the first step runs alongside it
                if (status.out_free)
                begin
                    cmd.emit  = 1'b1;
                    cmd.sel   = mcsg_pkg::SEL_CENTRE;
                    cmd.last  = !status.walk_more;
                    cmd.step  = status.walk_more;
                    quad_next = 2'd0;
                    state_next = status.walk_more ? ST_QUAD : ST_IDLE;
                end
            end
            ST_QUAD:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    unique case (quad_reg)
                        2'd0: cmd.sel = mcsg_pkg::SEL_Q0;
                        2'd1: cmd.sel = mcsg_pkg::SEL_Q1;
                        2'd2: cmd.sel = mcsg_pkg::SEL_Q2;
                        2'd3: cmd.sel = mcsg_pkg::SEL_Q3;
                        default: cmd.sel = mcsg_pkg::SEL_Q0;
                    endcase
                    quad_next = quad_reg + 2'd1;
                    if (quad_reg == 2'd3)
                    begin
                        // next step overlaps the fourth pair of this group
                        cmd.last   = !status.walk_more;
                        cmd.step   = status.walk_more;
                        state_next = status.walk_more ? ST_QUAD : ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            quad_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            quad_reg  <= quad_next;
        end
    end

endmodule

FILE: design/midpoint_circle_span_generator.sv
`timescale 1ns / 1ps
// Channel  | Dir | tdata (low bit first)                      | tuser        | tlast
// s_axis   | in  | centre_x[9:0], centre_y[9:0], radius[3:0]  | filled       | -
// m_axis   | out | x_left[11:0], x_right[11:0], row_y[11:0]   | fill_between | last
//
// Each command is loaded in idle, then gives the two axis pairs, the centre row and four pairs per walk step.
// One pair leaves the single output register per cycle while m_axis does not stall; the walk step shares
// the cycle of the centre row and of each fourth pair.
// Reset (rst_n, async, active low) returns to idle with no transfer pending.
// Back-pressure on m_axis holds the walk; s_axis_tready is high only when idle.

module midpoint_circle_span_generator #(
    parameter int MAX_RADIUS = 15,
    parameter int COORD_BITS = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [mcsg_pkg::S_TDATA_W-1:0] s_axis_tdata,  // centre_x, centre_y, radius
    input  logic                           s_axis_tuser,  // filled
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [mcsg_pkg::M_TDATA_W-1:0] m_axis_tdata,  // x_left, x_right, row_y, pad
    output logic                           m_axis_tuser,  // fill_between
    output logic                           m_axis_tlast
);

    mcsg_pkg::dp_cmd_t    cmd;
    mcsg_pkg::dp_status_t status;

    mcsg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mcsg_datapath #(
        .MAX_RADIUS (MAX_RADIUS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .m_tlast  (m_axis_tlast)
    );

endmodule

FILE: design/mcsg_checker.sv
`timescale 1ns / 1ps

module mcsg_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [mcsg_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tlast
);

    // one command at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted again while a command is in progress");

    // only the final pair of the previous command may still wait at a new accept
    a_accept_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> !(m_axis_tvalid && !m_axis_tlast))
        else $error("new command taken before previous run finished");

    a_span_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            $signed(m_axis_tdata[11:0]) <= $signed(m_axis_tdata[23:12]))
        else $error("left column beyond right column");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output transfer changed while stalled");

endmodule

bind midpoint_circle_span_generator mcsg_checker u_mcsg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: verif/tb_midpoint_circle_span_generator.sv
`timescale 1ns / 1ps

module tb_midpoint_circle_span_generator;

    localparam int MAX_RADIUS     = 15;
    localparam int COORD_BITS     = 10;
    localparam int IDLE_PERCENT   = 19;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 60;
    localparam int CW             = mcsg_pkg::COORD_W;

    typedef struct packed {
        logic [CW-1:0] x_left;
        logic [CW-1:0] x_right;
        logic [CW-1:0] row_y;
        logic          fill_between;
        logic          last;
    } span_pair_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [mcsg_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                           s_axis_tuser = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [mcsg_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tuser;
    logic                           m_axis_tlast;

    span_pair_t pairs_due[$];
    int         errors = 0;
    int         quiet_cycles = 0;
    logic       steady = 1'b0;        // no random idling on either side while set
    logic       receiver_hold = 1'b0;
    event       hold_trigger;

    midpoint_circle_span_generator #(
        .MAX_RADIUS(MAX_RADIUS),
        .COORD_BITS(COORD_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),   // centre_x, centre_y, radius
        .s_axis_tuser (s_axis_tuser),   // filled
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),   // x_left, x_right, row_y, pad
        .m_axis_tuser (m_axis_tuser),   // fill_between
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // columns and rows wrap to the 12-bit output fields
    function automatic span_pair_t make_pair(input int xl, input int xr, input int row,
                                             input logic fill);
        span_pair_t p;
        p.x_left       = CW'(xl);
        p.x_right      = CW'(xr);
        p.row_y        = CW'(row);
        p.fill_between = fill;
        p.last         = 1'b0;
        return p;
    endfunction

    // Expands one circle into its row pairs and queues them in output order.
    function automatic void expand_circle(input logic [9:0] cx_in, input logic [9:0] cy_in,
                                          input logic [3:0] rad_in, input logic filled);
        span_pair_t batch[$];
        int cx, cy, r, px, py, disc;
        cx = int'(cx_in) & ((1 << COORD_BITS) - 1);
        cy = int'(cy_in) & ((1 << COORD_BITS) - 1);
        r  = (int'(rad_in) > MAX_RADIUS) ? MAX_RADIUS : int'(rad_in);
        px = 0;
        py = r;
        disc = 1 - r;
        batch.push_back(make_pair(cx, cx, cy + r, filled));
        batch.push_back(make_pair(cx, cx, cy - r, filled));
        batch.push_back(make_pair(cx - r, cx + r, cy, filled));
        while (px < py)
        begin
            px++;
            if (disc <= 0)
                disc += 2 * px + 1;
            else
            begin
                py--;
                disc += 2 * (px - py) + 1;
            end
            batch.push_back(make_pair(cx - py, cx + py, cy + px, filled));
            batch.push_back(make_pair(cx - py, cx + py, cy - px, filled));
            batch.push_back(make_pair(cx - px, cx + px, cy + py, filled));
            batch.push_back(make_pair(cx - px, cx + px, cy - py, filled));
        end
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            pairs_due.push_back(batch[i]);
    endfunction

    task automatic offer_circle(input logic [9:0] cx, input logic [9:0] cy,
                                input logic [3:0] rad, input logic filled);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rad, cy, cx};
        s_axis_tuser  <= filled;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expand_circle(cx, cy, rad, filled);
    endtask

    task automatic offer_random_circle();
        offer_circle(10'($urandom_range(1023)), 10'($urandom_range(1023)),
                     4'($urandom_range(15)), 1'($urandom_range(1)));
    endtask

    task automatic wait_for_drain();
        while (pairs_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        offer_circle(10'd512, 10'd512, 4'd0, 1'b1);   // zero radius, all at centre
        offer_circle(10'd512, 10'd512, 4'd0, 1'b0);
        offer_circle(10'd0, 10'd0, 4'd15, 1'b1);      // columns and rows go negative
        offer_circle(10'd0, 10'd0, 4'd15, 1'b0);
        offer_circle(10'd1023, 10'd1023, 4'd15, 1'b1);
        offer_circle(10'd1023, 10'd0, 4'd15, 1'b0);
        offer_circle(10'd0, 10'd1023, 4'd15, 1'b1);
        for (int r = 1; r < 15; r++)
            offer_circle(10'h2aa, 10'h155, r[3:0], r[0]);
        offer_circle(10'h155, 10'h2aa, 4'd7, 1'b1);
        offer_circle(10'd1023, 10'd1023, 4'd1, 1'b0);
    endtask

    // Sink stalls for a long stretch while large circles keep coming.
    task automatic test_back_pressure();
        -> hold_trigger;
        steady <= 1'b1;
        for (int i = 0; i < 6; i++)
            offer_circle(10'($urandom_range(1023)), 10'($urandom_range(1023)), 4'd15,
                         1'($urandom_range(1)));
        steady <= 1'b0;
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 3; i++)
            offer_random_circle();
        s_axis_tvalid <= 1'b0;
        wait_for_drain();
        for (int i = 0; i < 3; i++)
            offer_random_circle();
    endtask

    task automatic test_random();
        for (int i = 0; i < 230; i++)
            offer_random_circle();
        steady <= 1'b1;
        for (int i = 0; i < 60; i++)
            offer_random_circle();
        steady <= 1'b0;
        for (int i = 0; i < 40; i++)
            offer_random_circle();
    endtask

    initial
    begin
        forever
        begin
            @(hold_trigger);
            receiver_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            receiver_hold <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : span_checker
        span_pair_t got;
        span_pair_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tdata[11:0], m_axis_tdata[23:12], m_axis_tdata[35:24],
                    m_axis_tuser, m_axis_tlast};
            if (pairs_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pair, expected none, got xl=%0d xr=%0d row=%0d",
                         $time, $signed(got.x_left), $signed(got.x_right),
                         $signed(got.row_y));
            end
            else
            begin
                want = pairs_due.pop_front();
                if (got.x_left !== want.x_left || got.x_right !== want.x_right ||
                    got.row_y !== want.row_y || got.fill_between !== want.fill_between ||
                    got.last !== want.last)
                begin
                    errors++;
                    $display("%0t: pair mismatch, expected xl=%0d xr=%0d row=%0d fill=%0b last=%0b",
                             $time, $signed(want.x_left), $signed(want.x_right),
                             $signed(want.row_y), want.fill_between, want.last);
                    $display("%0t:                 got xl=%0d xr=%0d row=%0d fill=%0b last=%0b",
                             $time, $signed(got.x_left), $signed(got.x_right),
                             $signed(got.row_y), got.fill_between, got.last);
                end
            end
        end
        m_axis_tready <= !receiver_hold && (steady || $urandom_range(99) >= IDLE_PERCENT);
    end

    // counts cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d pairs outstanding",
                         $time, quiet_cycles, pairs_due.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_back_pressure();
        test_drain_pause();
        test_random();
        s_axis_tvalid <= 1'b0;
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
design/mcsg_pkg.sv
design/mcsg_datapath.sv
design/mcsg_ctrl.sv
design/midpoint_circle_span_generator.sv
design/mcsg_checker.sv
verif/tb_midpoint_circle_span_generator.sv
